/* rtl/mprr_pkg.sv */
// shared types, constants and the crc byte function for the modbus pressure reply receiver
`timescale 1ns / 1ps

package mprr_pkg;

  localparam int FRAME_BYTES = 7;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  FUNC_READ = 8'h03;
  localparam logic [7:0]  COUNT_TWO = 8'h02;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_CRC   = 3'd1;
  localparam logic [2:0] ERR_ADDR  = 3'd2;
  localparam logic [2:0] ERR_FUNC  = 3'd3;
  localparam logic [2:0] ERR_COUNT = 3'd4;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_ADDR  = 2'd1;
  localparam logic [1:0] FAULT_FUNC  = 2'd2;
  localparam logic [1:0] FAULT_COUNT = 2'd3;

  localparam int CFG_SLAVE_ADDRESS = 0;
  localparam int CFG_CALIBRATION   = 1;

  localparam logic [7:0]         SLAVE_ADDRESS_RESET = 8'd1;
  localparam logic signed [10:0] CALIBRATION_RESET   = 11'sd0;
  localparam logic signed [21:0] PRESSURE_RESET      = 22'sd194560;
  localparam logic signed [22:0] PRESSURE_LOW        = -23'sd264704;
  localparam logic signed [22:0] PRESSURE_HIGH       = 23'sd1517824;

  localparam logic [15:0] RAW_ZERO_SUBST = 16'd10000;
  localparam logic signed [11:0] CAL_BIAS = 12'sd10;

  // 389120 / 20265 reduced to 77824 / 4053, applied as a scaled reciprocal
  localparam longint unsigned CONV_NUM  = 77824;
  localparam longint unsigned CONV_DEN  = 4053;
  localparam int              FRAC_BITS = 28;
  localparam longint unsigned RECIP_FULL = ((CONV_NUM << FRAC_BITS) + CONV_DEN - 1) / CONV_DEN;
  localparam logic [32:0]     RECIP = RECIP_FULL[32:0];
  // fraction bits at or above this place mean the division left a remainder
  localparam int              REM_LSB = 16;

  typedef struct packed {
    logic        done;
    logic [2:0]  err;
    logic [15:0] raw;
  } frame_res_t;

  typedef struct packed {
    logic [2:0]         err;
    logic [15:0]        raw;
    logic signed [21:0] pressure;
  } out_item_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/mprr_frame.sv */
// frame tracker: byte position, crc, header checks and value word capture
`timescale 1ns / 1ps

module mprr_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  input  logic [7:0]          slave_address,
  output logic [15:0]         value_word,
  output mprr_pkg::frame_res_t res
);
  import mprr_pkg::*;

  localparam logic [2:0] POS_ADDR   = 3'd0;
  localparam logic [2:0] POS_FUNC   = 3'd1;
  localparam logic [2:0] POS_COUNT  = 3'd2;
  localparam logic [2:0] POS_VAL_HI = 3'd3;
  localparam logic [2:0] POS_VAL_LO = 3'd4;
  localparam logic [2:0] POS_CRC_LO = 3'd5;
  localparam logic [2:0] POS_CRC_HI = 3'(FRAME_BYTES - 1);
  localparam logic [2:0] POS_IDLE   = 3'(FRAME_BYTES);

  logic [2:0]  pos_r, pos_nxt, pos_e;
  logic [15:0] crc_r, crc_nxt, crc_e;
  logic [1:0]  fault_r, fault_nxt, fault_e;
  logic [15:0] value_r, value_nxt, value_e;
  logic [7:0]  crc_lo_r, crc_lo_nxt, crc_lo_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_ADDR;
      crc_r    <= CRC_SEED;
      fault_r  <= FAULT_NONE;
      value_r  <= '0;
      crc_lo_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      fault_r  <= fault_nxt;
      value_r  <= value_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  always_comb begin
    pos_e    = frame_start ? POS_ADDR : pos_r;
    crc_e    = frame_start ? CRC_SEED : crc_r;
    fault_e  = frame_start ? FAULT_NONE : fault_r;
    value_e  = frame_start ? 16'h0000 : value_r;
    crc_lo_e = frame_start ? 8'h00 : crc_lo_r;

    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    fault_nxt  = fault_r;
    value_nxt  = value_r;
    crc_lo_nxt = crc_lo_r;
    res        = '0;

    if (in_fire) begin
      pos_nxt    = pos_e;
      crc_nxt    = crc_e;
      fault_nxt  = fault_e;
      value_nxt  = value_e;
      crc_lo_nxt = crc_lo_e;
      if (pos_e < POS_IDLE) begin
        if (pos_e <= POS_VAL_LO) begin
          crc_nxt = crc16_byte(crc_e, rx_byte);
        end
        case (pos_e)
          POS_ADDR: begin
            if (rx_byte != slave_address && fault_e == FAULT_NONE) fault_nxt = FAULT_ADDR;
          end
          POS_FUNC: begin
            if (rx_byte != FUNC_READ && fault_e == FAULT_NONE) fault_nxt = FAULT_FUNC;
          end
          POS_COUNT: begin
            if (rx_byte != COUNT_TWO && fault_e == FAULT_NONE) fault_nxt = FAULT_COUNT;
          end
          POS_VAL_HI: value_nxt = {rx_byte, 8'h00};
          POS_VAL_LO: value_nxt = {value_e[15:8], rx_byte};
          POS_CRC_LO: crc_lo_nxt = rx_byte;
          default: ;
        endcase
        if (pos_e == POS_CRC_HI) begin
          res.done = 1'b1;
          res.raw  = value_e;
          if ({rx_byte, crc_lo_e} != crc_e) begin
            res.err = ERR_CRC;
          end else begin
            case (fault_e)
              FAULT_ADDR:  res.err = ERR_ADDR;
              FAULT_FUNC:  res.err = ERR_FUNC;
              FAULT_COUNT: res.err = ERR_COUNT;
              default:     res.err = ERR_OK;
            endcase
          end
          pos_nxt = POS_IDLE;
        end else begin
          pos_nxt = pos_e + 3'd1;
        end
      end
    end
  end

  assign value_word = value_r;

endmodule

/* rtl/mprr_conv.sv */
// raw word to q8 pressure conversion with calibration, saturation and last good hold
`timescale 1ns / 1ps

module mprr_conv (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        value_word,
  input  logic signed [10:0] calibration,
  input  logic               load,
  input  logic               ok,
  output logic signed [21:0] pressure
);
  import mprr_pkg::*;

  logic [15:0]        r_eff;
  logic [48:0]        prod_r;
  logic [20:0]        quot;
  logic               rem_nz;
  logic signed [11:0] cal_adj;
  logic signed [22:0] offset;
  logic signed [22:0] sum;
  logic signed [22:0] sum_adj;
  logic signed [21:0] sat;
  logic signed [21:0] last_r, last_nxt;

  assign r_eff = (value_word == 16'h0000) ? RAW_ZERO_SUBST : value_word;

  // value word settles two items before the frame ends, so the product is ready in time
  always_ff @(posedge clk) begin
    prod_r <= {33'h0, r_eff} * {16'h0, RECIP};
  end

  always_comb begin
    quot    = prod_r[48:FRAC_BITS];
    rem_nz  = |prod_r[FRAC_BITS-1:REM_LSB];
    cal_adj = 12'(calibration) - CAL_BIAS;
    offset  = 23'(cal_adj) <<< 8;
    sum     = $signed({2'b00, quot}) + offset;
    // truncation toward zero rounds a negative inexact quotient up
    sum_adj = (sum < 0 && rem_nz) ? sum + 23'sd1 : sum;
    if (sum_adj < PRESSURE_LOW) begin
      sat = PRESSURE_LOW[21:0];
    end else if (sum_adj > PRESSURE_HIGH) begin
      sat = PRESSURE_HIGH[21:0];
    end else begin
      sat = sum_adj[21:0];
    end
    last_nxt = (load && ok) ? sat : last_r;
    pressure = ok ? sat : last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= PRESSURE_RESET;
    end else begin
      last_r <= last_nxt;
    end
  end

endmodule

/* rtl/mprr_out_buf.sv */
// two-entry result buffer: output register plus skid register
`timescale 1ns / 1ps

module mprr_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mprr_pkg::out_item_t  push_item,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mprr_pkg::out_item_t  out_item
);
  import mprr_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  out_item_t skid_item_r, skid_item_nxt;
  logic      pop;

  assign pop   = out_valid_r && out_ready;
  assign ready = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_item_nxt   = out_item_r;
    skid_item_nxt  = skid_item_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_item_nxt  = push_item;
        out_valid_nxt = 1'b1;
      end else begin
        skid_item_nxt  = push_item;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/modbus_pressure_reply_receiver_unit.sv */
// top level: modbus rtu read reply receiver with crc check and pressure conversion
// result: a frame's result enters the output buffer as its seventh byte is taken
// throughput: one byte per cycle; the result buffer holds two items, so input stalls
//   only while both are waiting; the conversion multiply runs on the value word
//   during the two crc bytes
// reset: synchronous active-low; clears the frame, sets registers to their defaults
//   and the held pressure to 760.0; no clearing pass
`timescale 1ns / 1ps

module modbus_pressure_reply_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic        in_tuser,   // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // error_code, raw_value, pressure_q8, zero fill
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata
);
  import mprr_pkg::*;

  logic [7:0]         slave_address_r;
  logic signed [10:0] calibration_r;
  logic               in_fire;
  logic [15:0]        value_word;
  frame_res_t         res;
  logic               push;
  logic               ok;
  logic signed [21:0] pressure;
  out_item_t          push_item;
  out_item_t          out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= SLAVE_ADDRESS_RESET;
      calibration_r   <= CALIBRATION_RESET;
    end else if (cfg_we) begin
      case (int'(cfg_index))
        CFG_SLAVE_ADDRESS: slave_address_r <= cfg_wdata[7:0];
        CFG_CALIBRATION:   calibration_r   <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign in_fire = in_tvalid && in_tready;

  mprr_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .rx_byte       (in_tdata),
    .frame_start   (in_tuser),
    .slave_address (slave_address_r),
    .value_word    (value_word),
    .res           (res)
  );

  assign push = res.done;
  assign ok   = (res.err == ERR_OK);

  mprr_conv u_conv (
    .clk         (clk),
    .rst_n       (rst_n),
    .value_word  (value_word),
    .calibration (calibration_r),
    .load        (push),
    .ok          (ok),
    .pressure    (pressure)
  );

  always_comb begin
    push_item.err      = res.err;
    push_item.raw      = res.raw;
    push_item.pressure = pressure;
  end

  mprr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = {7'h00, out_item.pressure, out_item.raw, out_item.err};

endmodule

/* tb/tb_modbus_pressure_reply_receiver_unit.sv */
// testbench for the modbus pressure reply receiver: random reply frames checked against a predictor
`timescale 1ns / 1ps

module tb_modbus_pressure_reply_receiver_unit;
  import mprr_pkg::*;

  localparam longint Q8_SCALE_NUM = 389120;
  localparam longint Q8_SCALE_DEN = 20265;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 250;
  localparam int HOLD_BACKLOG = 60;

  typedef struct {
    logic [7:0] value;
    logic       start;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // rx_byte
  logic        in_tuser = 1'b0;    // frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;          // error_code, raw_value, pressure_q8, zero fill
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_wdata = 11'd0;

  modbus_pressure_reply_receiver_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // byte stream waiting to be sent and replies still owed by the block
  rx_item_t  byte_queue[$];
  out_item_t expected_readings[$];

  // predictor copy of registers and frame state
  logic [7:0]         slave_addr;
  logic signed [10:0] cal_offset;
  logic [2:0]         frame_pos;
  logic [15:0]        crc_acc;
  logic [1:0]         hdr_fault;
  logic [15:0]        word_acc;
  logic [7:0]         crc_lo;
  logic signed [21:0] held_pressure;

  int  mismatch_count = 0;
  int  readings_seen = 0;
  int  bytes_planned = 0;
  bit  idle_on = 1'b1;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  quiet_cycles = 0;

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ ((c[0] ^ b[i]) ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic logic signed [21:0] to_pressure(input logic [15:0] raw);
    longint r;
    longint num;
    longint q;
    r = (raw == 16'd0) ? longint'(RAW_ZERO_SUBST) : longint'(raw);
    num = r * Q8_SCALE_NUM + (longint'(cal_offset) - longint'(CAL_BIAS)) * 256 * Q8_SCALE_DEN;
    q = num / Q8_SCALE_DEN;
    if (q < longint'(PRESSURE_LOW)) q = longint'(PRESSURE_LOW);
    if (q > longint'(PRESSURE_HIGH)) q = longint'(PRESSURE_HIGH);
    return q[21:0];
  endfunction

  function automatic void restart_frame();
    frame_pos = 3'd0;
    crc_acc = CRC_SEED;
    hdr_fault = FAULT_NONE;
    word_acc = 16'd0;
    crc_lo = 8'd0;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic start);
    logic [2:0] err;
    out_item_t  reading;
    if (start) restart_frame();
    if (frame_pos >= FRAME_BYTES) return;
    if (frame_pos <= 3'd4) crc_acc = crc_step(crc_acc, b);
    case (frame_pos)
      3'd0: if (b != slave_addr && hdr_fault == FAULT_NONE) hdr_fault = FAULT_ADDR;
      3'd1: if (b != FUNC_READ && hdr_fault == FAULT_NONE) hdr_fault = FAULT_FUNC;
      3'd2: if (b != COUNT_TWO && hdr_fault == FAULT_NONE) hdr_fault = FAULT_COUNT;
      3'd3: word_acc = {b, 8'h00};
      3'd4: word_acc = {word_acc[15:8], b};
      3'd5: crc_lo = b;
      default: ;
    endcase
    if (frame_pos != 3'(FRAME_BYTES - 1)) begin
      frame_pos = frame_pos + 3'd1;
      return;
    end
    if ({b, crc_lo} != crc_acc) begin
      err = ERR_CRC;
    end else begin
      case (hdr_fault)
        FAULT_ADDR:  err = ERR_ADDR;
        FAULT_FUNC:  err = ERR_FUNC;
        FAULT_COUNT: err = ERR_COUNT;
        default:     err = ERR_OK;
      endcase
    end
    if (err == ERR_OK) held_pressure = to_pressure(word_acc);
    reading.err = err;
    reading.raw = word_acc;
    reading.pressure = held_pressure;
    expected_readings.push_back(reading);
    frame_pos = 3'(FRAME_BYTES);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 50) $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_reading(input logic [47:0] data);
    out_item_t want;
    logic [2:0]  got_err;
    logic [15:0] got_raw;
    logic [21:0] got_press;
    got_err = data[2:0];
    got_raw = data[18:3];
    got_press = data[40:19];
    if (expected_readings.size() == 0) begin
      report_mismatch($sformatf("unexpected reply err=%0d raw=%h", got_err, got_raw));
      return;
    end
    want = expected_readings.pop_front();
    if (got_err !== want.err)
      report_mismatch($sformatf("error code %0d, want %0d", got_err, want.err));
    if (got_raw !== want.raw)
      report_mismatch($sformatf("raw value %h, want %h", got_raw, want.raw));
    if (got_press !== want.pressure)
      report_mismatch($sformatf("pressure %0d, want %0d",
                                $signed(got_press), want.pressure));
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_byte(byte_queue[0].value, byte_queue[0].start);
        void'(byte_queue.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap == 0 && idle_on && $urandom_range(0, 11) == 0)
          send_gap = $urandom_range(1, 15);
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= byte_queue[0].value;
          in_tuser <= byte_queue[0].start;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_reading(out_tdata);
        readings_seen++;
      end
      // long hold only while plenty of bytes are still queued, so the input backs up
      if (!hold_done && readings_seen >= 30 && byte_queue.size() >= HOLD_BACKLOG) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 15);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_modbus_pressure_reply_receiver_unit: errors");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic start);
    rx_item_t it;
    it.value = b;
    it.start = start;
    byte_queue.push_back(it);
    bytes_planned++;
  endtask

  task automatic push_frame(input logic [7:0] addr, input logic [7:0] func,
                            input logic [7:0] cnt, input logic [15:0] raw,
                            input bit bad_crc, input bit with_start, input int len);
    logic [7:0]  fb[7];
    logic [15:0] c;
    fb[0] = addr;
    fb[1] = func;
    fb[2] = cnt;
    fb[3] = raw[15:8];
    fb[4] = raw[7:0];
    c = CRC_SEED;
    for (int i = 0; i < 5; i++) c = crc_step(c, fb[i]);
    if (bad_crc) c = c ^ (16'd1 << $urandom_range(0, 15));
    fb[5] = c[7:0];
    fb[6] = c[15:8];
    for (int i = 0; i < len; i++) push_byte(fb[i], with_start && i == 0);
  endtask

  task automatic cfg_write(input int idx, input logic [10:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 1'(idx);
    cfg_wdata <= data;
    if (idx == CFG_SLAVE_ADDRESS) slave_addr = data[7:0];
    else cal_offset = data;
  endtask

  task automatic set_registers(input logic [7:0] addr, input logic signed [10:0] cal);
    cfg_write(CFG_SLAVE_ADDRESS, {3'b000, addr});
    cfg_write(CFG_CALIBRATION, cal);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (byte_queue.size() != 0 || expected_readings.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_raw();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'h0000;
    if (k == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic random_frames(input int n_bytes);
    int stop_at;
    int kind;
    logic [7:0] a;
    logic [7:0] f;
    logic [7:0] n;
    stop_at = bytes_planned + n_bytes;
    while (bytes_planned < stop_at) begin
      kind = $urandom_range(0, 99);
      a = slave_addr;
      f = FUNC_READ;
      n = COUNT_TWO;
      if (kind < 62) begin
        push_frame(a, f, n, pick_raw(), 1'b0, 1'b1, 7);
      end else if (kind < 77) begin
        if ($urandom_range(0, 1)) a = a ^ 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) f = f ^ 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) n = n ^ 8'($urandom_range(1, 255));
        push_frame(a, f, n, pick_raw(), 1'b0, 1'b1, 7);
      end else if (kind < 84) begin
        if ($urandom_range(0, 2) == 0) f = 8'($urandom_range(0, 255));
        push_frame(a, f, n, pick_raw(), 1'b1, 1'b1, 7);
      end else if (kind < 90) begin
        push_frame(a, f, n, pick_raw(), 1'b0, 1'b1, $urandom_range(1, 6));
      end else if (kind < 95) begin
        push_frame(a, f, n, pick_raw(), 1'b0, 1'b1, 7);
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 8))
          push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    slave_addr = SLAVE_ADDRESS_RESET;
    cal_offset = CALIBRATION_RESET;
    held_pressure = PRESSURE_RESET;
    restart_frame();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // first frame right after reset carries no start flag; raw zero is substituted
    push_frame(SLAVE_ADDRESS_RESET, FUNC_READ, COUNT_TWO, 16'h0000, 1'b0, 1'b0, 7);
    push_byte(8'hFF, 1'b0);
    // partial frame dropped by a restart
    push_frame(8'h00, 8'hFF, 8'h00, 16'hFFFF, 1'b0, 1'b1, 2);
    push_frame(8'h00, FUNC_READ, COUNT_TWO, 16'hFFFF, 1'b0, 1'b1, 7);
    // crc error outranks function and count faults
    push_frame(SLAVE_ADDRESS_RESET, 8'h04, 8'hFF, 16'h8001, 1'b1, 1'b1, 7);
    wait_drained();
    random_frames(250);
    wait_drained();

    set_registers(8'hFF, -11'sd1024);
    random_frames(250);
    wait_drained();

    set_registers(8'h00, 11'sd1023);
    random_frames(250);
    wait_drained();

    set_registers(8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
    random_frames(250);
    wait_drained();

    set_registers(SLAVE_ADDRESS_RESET, 11'($urandom_range(0, 2047)));
    idle_on = 1'b0;
    random_frames(300);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("tb_modbus_pressure_reply_receiver_unit: clean");
    end else begin
      $display("tb_modbus_pressure_reply_receiver_unit: errors");
    end
    $finish;
  end

endmodule
